/* rtl/assert_macros.svh */
// Assertion macros for the list engine. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant");
// post must hold in the cycle after pre
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle check");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* rtl/ple_pkg.sv */
package ple_pkg;

  // operation codes
  localparam logic [2:0] OP_CREATE    = 3'd0;
  localparam logic [2:0] OP_PROBE     = 3'd1;
  localparam logic [2:0] OP_VIEW      = 3'd2;
  localparam logic [2:0] OP_INSERT    = 3'd3;
  localparam logic [2:0] OP_DEL_VALUE = 3'd4;
  localparam logic [2:0] OP_DEL_POS   = 3'd5;
  localparam logic [2:0] OP_DEL_MATCH = 3'd6;
  localparam logic [2:0] OP_DESTROY   = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_POS  = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // per-cell commands, broadcast to the whole row
  localparam logic [2:0] CELL_HOLD   = 3'd0;
  localparam logic [2:0] CELL_ROT    = 3'd1;
  localparam logic [2:0] CELL_REMOVE = 3'd2;
  localparam logic [2:0] CELL_INSERT = 3'd3;
  localparam logic [2:0] CELL_SORT   = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         position;
    logic signed [31:0] value;
  } ple_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_value;
    logic [6:0]         entry_count;
    logic               list_created;
    logic [6:0]         removed_count;
  } ple_out_t;

  typedef struct packed {
    logic [2:0]         code;
    logic [7:0]         pos0;    // zero-based target position
    logic signed [31:0] value;   // word written on insert
    logic               parity;  // odd/even pairing for the sort pass
  } cell_ctl_t;

endpackage

/* rtl/positional_list_engine.sv */
// Channel   Handshake                    Payload
// -------   ---------------------------  ----------------------------------
// command   start in, busy out           cmd    (op, position, value)
// result    done out, one-cycle strobe   result (status, entry_value,
//                                                entry_count, list_created,
//                                                removed_count)
//
// A command word is taken on a rising edge with start high and busy low.
// Create, probe, insert, destroy and any bad position: result strobes on
// the cycle after the command. View, delete position and delete if match:
// the cell row rotates one cell per cycle past its head, then the result
// strobes from the FIN state. Delete value: the full rotation is followed
// by DEPTH odd/even compaction rounds.
// Reset clears count, list flag and sequencer; cell contents stay as they
// are. The receiver cannot stall; a new command may be taken in the cycle
// its predecessor's result strobes.
`include "assert_macros.svh"

module positional_list_engine #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ple_pkg::ple_in_t  cmd,
  output logic              done,
  output ple_pkg::ple_out_t result
);
  import ple_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);   // count width, holds 0..DEPTH
  localparam int IW = $clog2(DEPTH);       // cell index / walk step width
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROT  = 2'd1;    // full rotation of the row
  localparam logic [1:0] S_SORT = 2'd2;    // compaction rounds
  localparam logic [1:0] S_FIN  = 2'd3;    // optional removal, then result

  logic [1:0]         state;
  logic [IW-1:0]      step;
  logic [CW-1:0]      count;
  logic               created;
  logic [2:0]         op_q;
  logic [7:0]         pos0_q;
  logic signed [31:0] val_q;
  logic signed [31:0] cap;       // word seen at the target position
  logic [CW-1:0]      removed;

  logic signed [31:0] data_row [DEPTH];
  logic               dead_row [DEPTH];
  logic signed [31:0] head;
  logic               head_match;
  logic               feed_dead;
  cell_ctl_t          ctl;

  logic               accept;
  logic [8:0]         pos_ext;
  logic [8:0]         cnt_ext;
  logic               pos_ok;
  logic               ins_ok;
  logic               full;
  logic               quick;     // command completes at the accept edge
  ple_out_t           q_res;
  logic [CW-1:0]      q_count;
  logic               q_created;
  logic               fin_remove;
  logic [CW-1:0]      sort_count;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign pos_ext = {1'b0, cmd.position};
  assign cnt_ext = 9'(count);
  assign pos_ok  = (cmd.position != 8'd0) && (pos_ext <= cnt_ext);
  assign ins_ok  = (cmd.position != 8'd0) && (pos_ext <= cnt_ext + 9'd1);
  assign full    = (count == CW'(DEPTH));

  // head of the row; during rotation it leaves and re-enters at the tail,
  // tagged dead when it lies past the count or matches the delete value
  assign head       = data_row[0];
  assign head_match = (head == val_q);
  assign feed_dead  = (CW'(step) >= count) || head_match;

  assign fin_remove = (op_q == OP_DEL_POS) || ((op_q == OP_DEL_MATCH) && (cap == val_q));
  assign sort_count = count - removed;

  // commands that complete at the accept edge
  always_comb begin
    quick     = 1'b1;
    q_count   = count;
    q_created = created;
    q_res     = '0;
    case (cmd.op)
      OP_CREATE: begin
        q_count   = CW'(1);
        q_created = 1'b1;
      end
      OP_PROBE: ;
      OP_VIEW, OP_DEL_POS, OP_DEL_MATCH: begin
        if (pos_ok) begin
          quick = 1'b0;
        end else begin
          q_res.status = ST_BAD_POS;
        end
      end
      OP_INSERT: begin
        if (!ins_ok) begin
          q_res.status = ST_BAD_POS;
        end else if (full) begin
          q_res.status = ST_FULL;
        end else begin
          q_count   = count + CW'(1);
          q_created = 1'b1;
        end
      end
      OP_DEL_VALUE: quick = 1'b0;
      default: begin
        q_count   = '0;
        q_created = 1'b0;
      end
    endcase
    q_res.entry_count  = 7'(q_count);
    q_res.list_created = q_created;
  end

  // row command
  always_comb begin
    ctl.code   = CELL_HOLD;
    ctl.pos0   = pos0_q;
    ctl.value  = val_q;
    ctl.parity = step[0];
    case (state)
      S_IDLE: begin
        if (accept && cmd.op == OP_CREATE) begin
          // create is an insert of zero at the front; the rest is stale
          ctl.code  = CELL_INSERT;
          ctl.pos0  = 8'd0;
          ctl.value = '0;
        end else if (accept && cmd.op == OP_INSERT && ins_ok && !full) begin
          ctl.code  = CELL_INSERT;
          ctl.pos0  = cmd.position - 8'd1;
          ctl.value = cmd.value;
        end
      end
      S_ROT:  ctl.code = CELL_ROT;
      S_SORT: ctl.code = CELL_SORT;
      S_FIN: begin
        if (fin_remove) begin
          ctl.code = CELL_REMOVE;
        end
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] l_data;
    logic               l_dead;
    logic signed [31:0] r_data;
    logic               r_dead;
    if (i == 0) begin : g_first
      assign l_data = '0;
      assign l_dead = 1'b0;
    end else begin : g_inner_l
      assign l_data = data_row[i-1];
      assign l_dead = dead_row[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign r_data = head;
      assign r_dead = feed_dead;
    end else begin : g_inner_r
      assign r_data = data_row[i+1];
      assign r_dead = dead_row[i+1];
    end
    ple_cell #(
      .INDEX (i),
      .DEPTH (DEPTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (l_data),
      .left_dead  (l_dead),
      .right_data (r_data),
      .right_dead (r_dead),
      .data       (data_row[i]),
      .dead       (dead_row[i])
    );
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= '0;
      count   <= '0;
      created <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q    <= cmd.op;
            pos0_q  <= cmd.position - 8'd1;
            val_q   <= cmd.value;
            step    <= '0;
            removed <= '0;
            if (quick) begin
              count   <= q_count;
              created <= q_created;
              result  <= q_res;
              done    <= 1'b1;
            end else begin
              state <= S_ROT;
            end
          end
        end
        S_ROT: begin
          if (pos0_q == 8'(step)) begin
            cap <= head;
          end
          if (op_q == OP_DEL_VALUE && CW'(step) < count && head_match) begin
            removed <= removed + CW'(1);
          end
          step <= step + IW'(1);
          if (step == LAST) begin
            step  <= '0;
            state <= (op_q == OP_DEL_VALUE) ? S_SORT : S_FIN;
          end
        end
        S_SORT: begin
          step <= step + IW'(1);
          if (step == LAST) begin
            step                 <= '0;
            state                <= S_IDLE;
            count                <= sort_count;
            result.status        <= ST_OK;
            result.entry_value   <= (removed != '0) ? val_q : '0;
            result.entry_count   <= 7'(sort_count);
            result.list_created  <= created;
            result.removed_count <= 7'(removed);
            done                 <= 1'b1;
          end
        end
        S_FIN: begin
          state               <= S_IDLE;
          done                <= 1'b1;
          result.list_created <= created;
          if (op_q == OP_VIEW) begin
            result.status        <= ST_OK;
            result.entry_value   <= cap;
            result.entry_count   <= 7'(count);
            result.removed_count <= '0;
          end else if (fin_remove) begin
            count                <= count - CW'(1);
            result.status        <= ST_OK;
            result.entry_value   <= cap;
            result.entry_count   <= 7'(count - CW'(1));
            result.removed_count <= 7'd1;
          end else begin
            result.status        <= ST_MISMATCH;
            result.entry_value   <= '0;
            result.entry_count   <= 7'(count);
            result.removed_count <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH))
  `ASSERT_ALWAYS(a_no_list_empty, created || count == '0)
  `ASSERT_NEXT(a_walk_busy, start && !busy && cmd.op == OP_DEL_VALUE, busy)
  `ASSERT_NEXT(a_fin_done, state == S_FIN, done && !busy)
  `ASSERT_ALWAYS(a_mismatch_keeps, !(done && result.status == ST_MISMATCH) || result.removed_count == '0)

endmodule

/* rtl/ple_cell.sv */
module ple_cell #(
  parameter int INDEX = 0,
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  ple_pkg::cell_ctl_t ctl,
  input  logic signed [31:0] left_data,
  input  logic               left_dead,
  input  logic signed [31:0] right_data,
  input  logic               right_dead,
  output logic signed [31:0] data,
  output logic               dead
);
  import ple_pkg::*;

  localparam logic [7:0] IDX       = 8'(INDEX);
  localparam logic       ODD       = 1'(INDEX % 2);
  localparam logic       HAS_LEFT  = (INDEX > 0);
  localparam logic       HAS_RIGHT = (INDEX + 1 < DEPTH);

  logic signed [31:0] data_next;
  logic               dead_next;
  logic               pair_left;
  logic               pair_right;

  // sort pass pairs cell j with j+1 when j matches the round parity
  assign pair_left  = HAS_RIGHT && (ODD == ctl.parity);
  assign pair_right = HAS_LEFT && (ODD != ctl.parity);

  always_comb begin
    data_next = data;
    dead_next = dead;
    case (ctl.code)
      CELL_ROT: begin
        data_next = right_data;
        dead_next = right_dead;
      end
      CELL_REMOVE: begin
        if (IDX >= ctl.pos0) begin
          data_next = right_data;
          dead_next = right_dead;
        end
      end
      CELL_INSERT: begin
        if (IDX > ctl.pos0) begin
          data_next = left_data;
          dead_next = left_dead;
        end else if (IDX == ctl.pos0) begin
          data_next = ctl.value;
        end
      end
      CELL_SORT: begin
        // dead words bubble right, live words keep their order
        if (pair_left && dead && !right_dead) begin
          data_next = right_data;
          dead_next = right_dead;
        end else if (pair_right && left_dead && !dead) begin
          data_next = left_data;
          dead_next = left_dead;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    dead <= dead_next;
  end

endmodule

/* tb/ple_result_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the list engine, tracks the list contents on every
// accepted command word and checks each result word against the oldest
// prediction.
module ple_result_checker #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  ple_pkg::ple_in_t  cmd,
  input  logic              done,
  input  ple_pkg::ple_out_t result,
  output int                errors,
  output int                outstanding,
  output int                list_len
);
  import ple_pkg::*;

  logic signed [31:0] cells [DEPTH];
  int                 n_entries;
  logic               list_made;
  ple_out_t           expected_q [$];

  initial begin
    errors      = 0;
    outstanding = 0;
    list_len    = 0;
    n_entries   = 0;
    list_made   = 1'b0;
    foreach (cells[k]) cells[k] = '0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  // close the gap left by the entry at idx
  function automatic void drop_entry(int idx);
    int i;
    for (i = idx; i + 1 < n_entries && i + 1 < DEPTH; i++)
      cells[i] = cells[i + 1];
    if (n_entries > 0)
      n_entries--;
  endfunction

  // apply one command to the tracked list, return the result it must give
  function automatic ple_out_t apply_list_op(ple_in_t w);
    ple_out_t r;
    int       pos;
    int       i;
    int       kept;
    int       removed;
    bit       pos_ok;
    r       = '0;
    pos     = int'(w.position);
    kept    = 0;
    removed = 0;
    pos_ok  = (pos >= 1) && (pos <= n_entries);
    case (w.op)
      OP_CREATE: begin
        cells[0]  = '0;
        n_entries = 1;
        list_made = 1'b1;
      end
      OP_PROBE: begin
      end
      OP_VIEW: begin
        if (pos_ok) r.entry_value = cells[pos - 1];
        else r.status = ST_BAD_POS;
      end
      OP_INSERT: begin
        if (pos < 1 || pos > n_entries + 1) begin
          r.status = ST_BAD_POS;
        end else if (n_entries >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = n_entries; i > pos - 1; i--)
            cells[i] = cells[i - 1];
          cells[pos - 1] = w.value;
          n_entries++;
          list_made = 1'b1;
        end
      end
      OP_DEL_VALUE: begin
        for (i = 0; i < n_entries && i < DEPTH; i++) begin
          if (cells[i] == w.value) begin
            removed++;
          end else begin
            cells[kept] = cells[i];
            kept++;
          end
        end
        n_entries = kept;
        if (removed > 0) r.entry_value = w.value;
      end
      OP_DEL_POS: begin
        if (pos_ok) begin
          r.entry_value = cells[pos - 1];
          drop_entry(pos - 1);
          removed = 1;
        end else begin
          r.status = ST_BAD_POS;
        end
      end
      OP_DEL_MATCH: begin
        if (!pos_ok) begin
          r.status = ST_BAD_POS;
        end else if (cells[pos - 1] != w.value) begin
          r.status = ST_MISMATCH;
        end else begin
          r.entry_value = cells[pos - 1];
          drop_entry(pos - 1);
          removed = 1;
        end
      end
      default: begin
        n_entries = 0;
        list_made = 1'b0;
      end
    endcase
    r.entry_count   = 7'(n_entries);
    r.list_created  = list_made;
    r.removed_count = 7'(removed);
    return r;
  endfunction

  always @(posedge clk) begin
    ple_out_t want;
    if (rst) begin
      n_entries = 0;
      list_made = 1'b0;
      expected_q.delete();
    end else begin
      if (start && !busy)
        expected_q.push_back(apply_list_op(cmd));
      if (done) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result word with none expected", result.entry_value, '0);
        end else begin
          want = expected_q.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", 32'(result.status), 32'(want.status));
          if (result.entry_value !== want.entry_value)
            report_mismatch("entry_value", result.entry_value, want.entry_value);
          if (result.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(result.entry_count),
                            32'(want.entry_count));
          if (result.list_created !== want.list_created)
            report_mismatch("list_created", 32'(result.list_created),
                            32'(want.list_created));
          if (result.removed_count !== want.removed_count)
            report_mismatch("removed_count", 32'(result.removed_count),
                            32'(want.removed_count));
        end
      end
    end
    outstanding <= expected_q.size();
    list_len    <= n_entries;
  end

endmodule

/* tb/positional_list_engine_tb.sv */
`timescale 1ns / 1ps

// Top of the list engine bench: drives command words, runs the watchdog and
// gives the verdict. All prediction and checking lives in ple_result_checker.
module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int DEPTH       = 64;
  localparam int N_RANDOM    = 900;
  localparam int N_PHASES    = 6;
  // slowest op is delete-by-value (rotation plus compaction); sender gaps are
  // geometric at 88% idle, so STALL_LIMIT quiet cycles means a hang
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 2 * DEPTH + 4;

  // shape of the op mix in a random phase
  typedef enum int {GROW, MIXED, SHRINK} mix_e;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  logic     done;
  ple_in_t  cmd;
  ple_out_t result;

  int errors;
  int outstanding;
  int list_len;
  int idle_pct;
  int quiet_cycles = 0;

  positional_list_engine #(.DEPTH(DEPTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  ple_result_checker #(.DEPTH(DEPTH)) chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding),
    .list_len    (list_len)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog: any accepted command or result word restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("positional_list_engine_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is
  // taken. At most one write to start per falling edge, so a start that
  // stays high across back-to-back words is never dropped and re-raised.
  task automatic put_word(logic [2:0] op, logic [7:0] pos, logic signed [31:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    cmd.op       <= op;
    cmd.position <= pos;
    cmd.value    <= val;
    // busy read right at the rising edge: value before the edge updates
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted result has come back.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // mostly a few extreme values so that matches happen, rest fully random
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1:    return 32'sh0000_0000;
      2, 3:    return 32'shFFFF_FFFF;
      4, 5:    return 32'sh7FFF_FFFF;
      6:       return 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // weights are percent, listed in opcode order (create .. destroy)
  function automatic logic [2:0] choose_op(mix_e mix);
    int wt [8];
    int r;
    int acc;
    int i;
    r   = $urandom_range(0, 99);
    acc = 0;
    case (mix)
      GROW:    wt = '{0, 4, 8, 74, 3, 6, 5, 0};   // no create/destroy: fill up
      MIXED:   wt = '{3, 5, 15, 35, 10, 15, 15, 2};
      default: wt = '{3, 5, 10, 15, 20, 25, 20, 2};
    endcase
    for (i = 0; i < 8; i++) begin
      acc += wt[i];
      if (r < acc) return 3'(i);
    end
    return OP_PROBE;
  endfunction

  // positions: mostly in range, some on the edges, some anywhere in 0..255
  function automatic logic [7:0] pick_position(int len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 8'($urandom_range(1, len + 1));
    if (r < 85) begin
      case ($urandom_range(0, 2))
        0:       return 8'd0;
        1:       return 8'(len);
        default: return 8'(len + 1);
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    mix_e mix;
    int   p;
    int   k;
    rst      = 1'b1;
    start    = 1'b0;
    cmd      = '0;
    idle_pct = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed part ----
    // no list yet: everything reports empty, bad positions
    put_word(OP_PROBE,     8'd0,   32'sd0);
    put_word(OP_VIEW,      8'd1,   32'sd0);
    put_word(OP_DEL_VALUE, 8'd0,   32'sd0);
    put_word(OP_DEL_POS,   8'd1,   32'sd0);
    put_word(OP_DEL_MATCH, 8'd1,   32'sd0);
    put_word(OP_INSERT,    8'd2,   32'sd5);            // only position 1 valid
    put_word(OP_INSERT,    8'd1,   32'sh7FFF_FFFF);    // insert creates the list
    put_word(OP_INSERT,    8'd0,   32'sd1);            // position zero
    put_word(OP_INSERT,    8'd2,   32'sh8000_0000);    // append at count+1
    put_word(OP_INSERT,    8'd1,   32'shFFFF_FFFF);    // new head
    put_word(OP_INSERT,    8'd255, 32'sd7);            // far past the end
    put_word(OP_VIEW,      8'd1,   32'sd0);
    put_word(OP_VIEW,      8'd3,   32'sd0);
    put_word(OP_VIEW,      8'd4,   32'sd0);            // one past count
    put_word(OP_DEL_MATCH, 8'd2,   32'sd0);            // mismatch
    put_word(OP_DEL_MATCH, 8'd2,   32'sh7FFF_FFFF);    // match, removes
    put_word(OP_DEL_POS,   8'd1,   32'sd0);            // first entry goes
    put_word(OP_INSERT,    8'd2,   32'sh8000_0000);    // two equal entries
    put_word(OP_DEL_VALUE, 8'd0,   32'sh8000_0000);    // both go, list emptied
    put_word(OP_PROBE,     8'd0,   32'sd0);            // empty but still created
    put_word(OP_CREATE,    8'd0,   32'sd0);
    put_word(OP_INSERT,    8'd1,   32'sd9);
    put_word(OP_CREATE,    8'd0,   32'sd0);            // create over a live list
    put_word(OP_DESTROY,   8'd0,   32'sd0);
    put_word(OP_DESTROY,   8'd0,   32'sd0);            // destroy with no list
    put_word(OP_PROBE,     8'd0,   32'sd0);
    drain();

    // ---- random part ----
    // phases pair an idle level (none, 88%, 13%) with an op mix; GROW twice
    // first so the list fills and the full-list paths get exercised
    for (p = 0; p < N_PHASES; p++) begin
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 88;
        default: idle_pct = 13;
      endcase
      case (p / 2)
        0:       mix = GROW;
        1:       mix = MIXED;
        default: mix = SHRINK;
      endcase
      for (k = 0; k < N_RANDOM / N_PHASES; k++)
        // list_len is the tracked count after the last accepted word
        put_word(choose_op(mix), pick_position(list_len), pick_value());
      drain();
    end

    // quiet tail: catch any stray result strobe after the last expected one
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("positional_list_engine_tb: PASS");
    end else begin
      $display("positional_list_engine_tb: FAIL");
    end
    $finish;
  end

endmodule
